// ----- rtl/scmef_pkg.sv -----
package scmef_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int CNT_W         = $clog2(FRACTION_BITS + 1);

	localparam int ID_W   = 11;
	localparam int RAW_W  = 16;
	localparam int ELAP_W = 10;
	localparam int SQ_W   = 2 * RAW_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 2'd2;

	localparam logic [ID_W-1:0]  DEVICE_ID_RST = '0;
	localparam logic [RAW_W-1:0] TIMEOUT_RST   = 16'd250;
	localparam logic [RAW_W-1:0] CUTOFF_RST    = 16'd1300;

	localparam logic [FRAC_W-1:0] FRAC_FULL = FRAC_W'(1) << FRACTION_BITS;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- rtl/scmef_if.sv -----
interface scmef_in_if import scmef_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ID_W-1:0]   frame_id;
	logic [RAW_W-1:0]  in_volt_raw;
	logic [RAW_W-1:0]  cap_volt_raw;
	logic [RAW_W-1:0]  in_curr_raw;
	logic [RAW_W-1:0]  target_pwr_raw;
	logic [ELAP_W-1:0] elapsed;

	modport source (
		output valid, op, frame_id, in_volt_raw, cap_volt_raw, in_curr_raw,
		       target_pwr_raw, elapsed,
		input  ready
	);
	modport sink (
		input  valid, op, frame_id, in_volt_raw, cap_volt_raw, in_curr_raw,
		       target_pwr_raw, elapsed,
		output ready
	);
endinterface

interface scmef_out_if import scmef_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              online;
	logic [RAW_W-1:0]  in_volt;
	logic [RAW_W-1:0]  cap_volt;
	logic [RAW_W-1:0]  in_curr;
	logic [RAW_W-1:0]  target_pwr;
	logic [FRAC_W-1:0] energy_fraction;

	modport source (
		output valid, online, in_volt, cap_volt, in_curr, target_pwr, energy_fraction,
		input  ready
	);
	modport sink (
		input  valid, online, in_volt, cap_volt, in_curr, target_pwr, energy_fraction,
		output ready
	);
endinterface

// ----- rtl/supercap_monitor_energy_fraction.sv -----
// Supercapacitor monitor: one status word out for every word in. A tick word or a frame
// with a foreign identifier goes straight to the done state after acceptance and presents
// its status once the output register is free. A frame for the configured device passes
// from acceptance to status through the shared squarer for input voltage, capacitor voltage
// and cutoff, a state to form numerator and denominator, one restoring divider step per
// fraction bit, a state to take the quotient and the done state that latches the status.
// A frame whose fraction needs no division skips the divider. The input is taken again once
// the status is latched in the output register, which may still wait for the consumer.
module supercap_monitor_energy_fraction import scmef_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	scmef_in_if.sink              in_ch,
	scmef_out_if.source           out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_IN,
		ST_SQ_CAP,
		ST_SQ_CUT,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [ID_W-1:0]   dev_id_q;
	logic [RAW_W-1:0]  timeout_q;
	logic [RAW_W-1:0]  cutoff_q;
	logic [RAW_W-1:0]  in_volt_q;
	logic [RAW_W-1:0]  cap_volt_q;
	logic [RAW_W-1:0]  in_curr_q;
	logic [RAW_W-1:0]  target_pwr_q;
	logic [FRAC_W-1:0] frac_q;
	logic              online_q;
	logic [RAW_W-1:0]  silence_q;
	logic [SQ_W-1:0]   in2_q;
	logic [SQ_W-1:0]   cap2_q;

	logic              out_valid_q;
	logic              out_online_q;
	logic [RAW_W-1:0]  out_in_volt_q;
	logic [RAW_W-1:0]  out_cap_volt_q;
	logic [RAW_W-1:0]  out_in_curr_q;
	logic [RAW_W-1:0]  out_target_pwr_q;
	logic [FRAC_W-1:0] out_frac_q;

	logic                     accept;
	logic                     out_free;
	logic [RAW_W-1:0]         sq_a;
	logic [SQ_W-1:0]          sq_p;
	logic [RAW_W:0]           sil_sum;
	logic [RAW_W-1:0]         sil_next;
	logic                     need_div;
	logic [SQ_W-1:0]          div_num;
	logic [SQ_W-1:0]          div_den;
	div_sts_t                 div_sts;
	logic [FRACTION_BITS-1:0] div_quo;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		unique case (state_q)
			ST_SQ_IN:  sq_a = in_volt_q;
			ST_SQ_CAP: sq_a = cap_volt_q;
			default:   sq_a = cutoff_q;
		endcase
	end

	scmef_sqr u_sqr (
		.clk (clk),
		.a   (sq_a),
		.p_q (sq_p)
	);

	assign sil_sum  = {1'b0, silence_q} + (RAW_W + 1)'(in_ch.elapsed);
	assign sil_next = sil_sum[RAW_W] ? '1 : sil_sum[RAW_W-1:0];

	assign need_div = (state_q == ST_PREP) && (in_volt_q > cutoff_q) && (cap2_q > sq_p) &&
		(cap2_q < in2_q);
	assign div_num  = cap2_q - sq_p;
	assign div_den  = in2_q - sq_p;

	scmef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (need_div),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dev_id_q     <= DEVICE_ID_RST;
			timeout_q    <= TIMEOUT_RST;
			cutoff_q     <= CUTOFF_RST;
			in_volt_q    <= '0;
			cap_volt_q   <= '0;
			in_curr_q    <= '0;
			target_pwr_q <= '0;
			frac_q       <= '0;
			online_q     <= 1'b0;
			silence_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DEVICE_ID: dev_id_q  <= cfg_data[ID_W-1:0];
					REG_TIMEOUT:   timeout_q <= cfg_data;
					REG_CUTOFF:    cutoff_q  <= cfg_data;
					default:       ;
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.op == OP_TICK) begin
							state_q   <= ST_DONE;
							silence_q <= sil_next;
							if (sil_next > timeout_q) begin
								in_volt_q    <= '0;
								cap_volt_q   <= '0;
								in_curr_q    <= '0;
								target_pwr_q <= '0;
								online_q     <= 1'b0;
							end
						end else if (in_ch.frame_id == dev_id_q) begin
							in_volt_q    <= in_ch.in_volt_raw;
							cap_volt_q   <= in_ch.cap_volt_raw;
							in_curr_q    <= in_ch.in_curr_raw;
							target_pwr_q <= in_ch.target_pwr_raw;
							silence_q    <= '0;
							online_q     <= 1'b1;
							state_q      <= ST_SQ_IN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SQ_IN:  state_q <= ST_SQ_CAP;
				ST_SQ_CAP: state_q <= ST_SQ_CUT;
				ST_SQ_CUT: state_q <= ST_PREP;
				ST_PREP: begin
					if (need_div) begin
						state_q <= ST_DIV;
					end else begin
						frac_q  <= (in_volt_q > cutoff_q && cap2_q > sq_p) ? FRAC_FULL : '0;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						frac_q  <= FRAC_W'(div_quo);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SQ_CAP) begin
			in2_q <= sq_p;
		end
		if (state_q == ST_SQ_CUT) begin
			cap2_q <= sq_p;
		end
		if (state_q == ST_DONE && out_free) begin
			out_online_q     <= online_q;
			out_in_volt_q    <= in_volt_q;
			out_cap_volt_q   <= cap_volt_q;
			out_in_curr_q    <= in_curr_q;
			out_target_pwr_q <= target_pwr_q;
			out_frac_q       <= frac_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.online          = out_online_q;
	assign out_ch.in_volt         = out_in_volt_q;
	assign out_ch.cap_volt        = out_cap_volt_q;
	assign out_ch.in_curr         = out_in_curr_q;
	assign out_ch.target_pwr      = out_target_pwr_q;
	assign out_ch.energy_fraction = out_frac_q;

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !div_sts.busy)
		else $error("input ready while divider busy");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q <= FRAC_FULL)
		else $error("fraction above full scale");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_frame_online: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.op == OP_FRAME && in_ch.frame_id == dev_id_q) |=> online_q)
		else $error("matching frame did not set online");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q && $stable(out_frac_q))
		else $error("pending status overwritten");

endmodule

// ----- rtl/scmef_sqr.sv -----
module scmef_sqr import scmef_pkg::*; (
	input  logic             clk,
	input  logic [RAW_W-1:0] a,
	output logic [SQ_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= SQ_W'(a) * SQ_W'(a);
	end

endmodule

// ----- rtl/scmef_div.sv -----
module scmef_div import scmef_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [SQ_W-1:0]          num,
	input  logic [SQ_W-1:0]          den,
	output div_sts_t                 sts,
	output logic [FRACTION_BITS-1:0] quo
);

	logic [SQ_W-1:0]          rem_q;
	logic [SQ_W-1:0]          den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [SQ_W:0]            shifted;
	logic [SQ_W:0]            diff;
	logic                     fits;

	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRACTION_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SQ_W-1:0] : shifted[SQ_W-1:0];
			quo_q <= {quo_q[FRACTION_BITS-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule
